>>> design/aes_pkg.sv
// Shared types, constants and field widths for the auto exposure search core.
// Depends on nothing; every other file imports it.
`default_nettype none

package aes_pkg;

  // Pixel format and fixed-point format of the shutter search
  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS  = 10;

  // Field widths
  localparam int PIX_W      = 12;
  localparam int SET_W      = 11;
  localparam int CNT_W      = 21;
  localparam int SV_W       = 22;
  localparam int LIM_W      = 22;
  localparam int TIME_W     = 20;
  localparam int DARK_W     = 13;
  localparam int PCT_W      = 7;
  localparam int FPIX_W     = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [PIX_W-1:0] PIX_MAX   = PIX_W'((1 << PIXEL_BITS) - 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Opcodes of an input item
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Exposure modes
  localparam logic MODE_SHT = 1'b0;
  localparam logic MODE_FBL = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_CONTRAST = 2'd2;

  // Frame classes
  localparam logic [1:0] CLS_GOOD  = 2'd0;
  localparam logic [1:0] CLS_UNDER = 2'd1;
  localparam logic [1:0] CLS_OVER  = 2'd2;
  localparam logic [1:0] CLS_BOTH  = 2'd3;

  // Setting ranges
  localparam logic [SET_W-1:0] SHT_MAX   = 11'd1055;
  localparam logic [SET_W-1:0] SHT_START = 11'd528;
  localparam logic [SET_W-1:0] FBL_MAX   = 11'd12;
  localparam logic [SET_W-1:0] FBL_START = 11'd6;
  localparam logic [SET_W-1:0] SET_ONE   = 11'd1;

  // Shutter values in fixed point
  localparam logic [SV_W-1:0] SHT_MAX_FX   = SV_W'(SHT_MAX) << FRAC_BITS;
  localparam logic [SV_W-1:0] SHT_START_FX = SV_W'(SHT_START) << FRAC_BITS;
  localparam logic [SV_W-1:0] ONE_FX       = SV_W'(1) << FRAC_BITS;
  localparam logic [SV_W-1:0] HALF_FX      = SV_W'(1) << (FRAC_BITS - 1);

  // Exposure limit: frame_pixels * percent / 100 by reciprocal, exact for 28-bit products
  localparam int LP_W           = FPIX_W + PCT_W;
  localparam int LIM_RECIP_W    = 29;
  localparam int LQ_W           = LP_W + LIM_RECIP_W;
  localparam int LIM_SHIFT      = 35;
  localparam logic [LIM_RECIP_W-1:0] LIM_RECIP = 29'd343597384;

  // Shutter conversion: floor((80*t + 9321) / 6342)
  localparam int SN_W           = 23;
  localparam int SHT_RECIP_W    = 24;
  localparam int SP_W           = SN_W + SHT_RECIP_W;
  localparam int SHT_SHIFT      = 36;
  localparam logic [SN_W-1:0] SHT_MUL  = 23'd80;
  localparam logic [SN_W-1:0] SHT_ADD  = 23'd9321;
  localparam logic [SHT_RECIP_W-1:0] SHT_RECIP = 24'd10835617;

  // Blanking conversion: floor((t + 41850) / 83700)
  localparam int FN_W           = 21;
  localparam int FBL_RECIP_W    = 22;
  localparam int FP_W           = FN_W + FBL_RECIP_W;
  localparam int FBL_SHIFT      = 38;
  localparam int FQ_W           = FP_W - FBL_SHIFT;
  localparam logic [FN_W-1:0] FBL_ADD  = 21'd41850;
  localparam logic [FBL_RECIP_W-1:0] FBL_RECIP = 22'd3284085;

  // Fixed time limits in microseconds
  localparam logic [TIME_W-1:0] T_MIN     = 20'd3;
  localparam logic [TIME_W-1:0] T_SHT_MAX = 20'd83560;
  localparam logic [TIME_W-1:0] T_MAX     = 20'd1004400;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_MODE   = 3'd0,
    CFG_FIXED_TIME   = 3'd1,
    CFG_DARK_LEVEL   = 3'd2,
    CFG_PERCENT      = 3'd3,
    CFG_FRAME_PIXELS = 3'd4
  } cfg_idx_t;

  // Search phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_PROBE = 4'b0010,
    PH_FBL   = 4'b0100,
    PH_SHT   = 4'b1000
  } phase_t;

  // One input item
  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } item_t;

  // One result item
  typedef struct packed {
    logic             mode;
    logic [SET_W-1:0] setting;
    logic             fin;
    logic [1:0]       status;
    logic [1:0]       cls;
  } res_t;

  // Outcome of the fixed time conversion
  typedef struct packed {
    logic             mode;
    logic [SET_W-1:0] setting;
    logic [1:0]       status;
  } fixed_t;

endpackage

`default_nettype wire

>>> design/aes_limit_calc.sv
// Exposure limit frame_pixels * percent / 100, two registered multiplies.
// Depends on aes_pkg.
`default_nettype none

module aes_limit_calc
  import aes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [FPIX_W-1:0] frame_pixels,
  input  wire logic [PCT_W-1:0]  percent,
  output logic      [LIM_W-1:0]  limit
);

  logic [LP_W-1:0] prod_r;
  logic [LQ_W-1:0] quot_r;

  // Product first, then multiply by the reciprocal of 100
  always_ff @(posedge clk) begin
    prod_r <= LP_W'(frame_pixels) * LP_W'(percent);
    quot_r <= LQ_W'(prod_r) * LQ_W'(LIM_RECIP);
  end

  assign limit = quot_r[LQ_W-1:LIM_SHIFT];

endmodule

`default_nettype wire

>>> design/aes_fixed_conv.sv
// Fixed exposure conversion: microseconds to shutter speed or blanking count.
// Depends on aes_pkg; the quotients come from registered reciprocal multiplies.
`default_nettype none

module aes_fixed_conv
  import aes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [TIME_W-1:0] time_us,
  output fixed_t                 fixed_res
);

  logic [SP_W-1:0]  sht_prod_r;
  logic [FP_W-1:0]  fbl_prod_r;
  logic [SN_W-1:0]  sht_num;
  logic [FN_W-1:0]  fbl_num;
  logic [SET_W-1:0] sht_q;
  logic [FQ_W-1:0]  fbl_q;

  // Numerators; the shutter one wraps only for times above T_SHT_MAX, where it is unused
  assign sht_num = SN_W'(time_us) * SHT_MUL + SHT_ADD;
  assign fbl_num = FN_W'(time_us) + FBL_ADD;

  always_ff @(posedge clk) begin
    sht_prod_r <= SP_W'(sht_num) * SP_W'(SHT_RECIP);
    fbl_prod_r <= FP_W'(fbl_num) * FP_W'(FBL_RECIP);
  end

  assign sht_q = sht_prod_r[SP_W-1:SHT_SHIFT];
  assign fbl_q = fbl_prod_r[FP_W-1:FBL_SHIFT];

  // Range select and clamp
  always_comb begin
    fixed_res = '{mode: MODE_SHT, setting: SET_ONE, status: ST_RANGE};
    if (time_us < T_MIN || time_us > T_MAX) begin
      fixed_res = '{mode: MODE_SHT, setting: SET_ONE, status: ST_RANGE};
    end else if (time_us <= T_SHT_MAX) begin
      fixed_res.mode   = MODE_SHT;
      fixed_res.status = ST_OK;
      if (sht_q > SHT_MAX)      fixed_res.setting = SHT_MAX;
      else if (sht_q < SET_ONE) fixed_res.setting = SET_ONE;
      else                      fixed_res.setting = sht_q;
    end else begin
      fixed_res.mode   = MODE_FBL;
      fixed_res.status = ST_OK;
      if (SET_W'(fbl_q) > FBL_MAX)      fixed_res.setting = FBL_MAX;
      else if (SET_W'(fbl_q) < SET_ONE) fixed_res.setting = SET_ONE;
      else                              fixed_res.setting = SET_W'(fbl_q);
    end
  end

endmodule

`default_nettype wire

>>> design/aes_search_fsm.sv
// Pixel counters, frame classing and the halving search state machine.
// Depends on aes_pkg; state advances only when the core's stage fires.
`default_nettype none

module aes_search_fsm
  import aes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  item_t                  item,
  input  wire logic              fixed_mode,
  input  wire logic [DARK_W-1:0] dark_level,
  input  wire logic [LIM_W-1:0]  limit,
  input  fixed_t                 fixed_res,
  output logic                   has_res,
  output res_t                   res
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] dark_cnt_r, dark_cnt_nxt;
  logic [CNT_W-1:0] sat_cnt_r, sat_cnt_nxt;
  logic [SV_W-1:0]  sv_r, sv_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;

  logic [PIX_W-1:0] pix;
  logic             is_dark, is_sat;
  logic [CNT_W-1:0] dark_new, sat_new;
  logic [1:0]       cls;
  logic [SV_W-1:0]  step_ext, adj, rnd_in, rnd;
  logic             fbl_out, sht_out, sht_high;

  // Per-pixel counting, saturating
  assign pix      = item.pixel & PIX_MAX;
  assign is_dark  = DARK_W'(pix) < dark_level;
  assign is_sat   = pix == PIX_MAX;
  assign dark_new = dark_cnt_r + CNT_W'(is_dark && dark_cnt_r != COUNT_MAX);
  assign sat_new  = sat_cnt_r + CNT_W'(is_sat && sat_cnt_r != COUNT_MAX);

  // Frame class from the counts including this pixel
  assign cls = {LIM_W'(sat_new) > limit, LIM_W'(dark_new) > limit};

  // Search step: under adds, over subtracts with floor at zero
  assign step_ext = SV_W'(step_r);
  always_comb begin
    adj = sv_r;
    if (cls == CLS_UNDER)     adj = sv_r + step_ext;
    else if (cls == CLS_OVER) adj = (step_ext > sv_r) ? '0 : sv_r - step_ext;
  end

  assign fbl_out  = adj > SV_W'(FBL_MAX) || adj == '0;
  assign sht_high = adj > SHT_MAX_FX;
  assign sht_out  = sht_high || adj < ONE_FX;

  // Shutter rounding half up; a finished search reports the value in use
  assign rnd_in = (cls == CLS_GOOD || cls == CLS_BOTH) ? sv_r : adj;
  assign rnd    = (rnd_in + HALF_FX) >> FRAC_BITS;

  always_comb begin
    phase_nxt    = phase_r;
    dark_cnt_nxt = dark_cnt_r;
    sat_cnt_nxt  = sat_cnt_r;
    sv_nxt       = sv_r;
    step_nxt     = step_r;
    has_res      = 1'b0;
    res          = '0;
    if (item.op == OP_START) begin
      dark_cnt_nxt = '0;
      sat_cnt_nxt  = '0;
      has_res      = 1'b1;
      if (fixed_mode) begin
        phase_nxt = PH_IDLE;
        res = '{mode: fixed_res.mode, setting: fixed_res.setting, fin: 1'b1,
                status: fixed_res.status, cls: CLS_GOOD};
      end else begin
        phase_nxt = PH_PROBE;
        res = '{mode: MODE_SHT, setting: SHT_MAX, fin: 1'b0, status: ST_OK, cls: CLS_GOOD};
      end
    end else if (phase_r != PH_IDLE) begin
      dark_cnt_nxt = dark_new;
      sat_cnt_nxt  = sat_new;
      if (item.last) begin
        dark_cnt_nxt = '0;
        sat_cnt_nxt  = '0;
        has_res      = 1'b1;
        res.cls      = cls;
        unique case (phase_r)
          PH_PROBE: begin
            if (cls == CLS_GOOD || cls == CLS_BOTH) begin
              phase_nxt   = PH_IDLE;
              res.mode    = MODE_SHT;
              res.setting = SHT_MAX;
              res.fin     = 1'b1;
              res.status  = (cls == CLS_BOTH) ? ST_CONTRAST : ST_OK;
            end else if (cls == CLS_UNDER) begin
              phase_nxt   = PH_FBL;
              sv_nxt      = SV_W'(FBL_START);
              step_nxt    = CNT_W'((FBL_START + SET_ONE) >> 1);
              res.mode    = MODE_FBL;
              res.setting = FBL_START;
            end else begin
              phase_nxt   = PH_SHT;
              sv_nxt      = SHT_START_FX;
              step_nxt    = CNT_W'(SHT_START_FX >> 1);
              res.mode    = MODE_SHT;
              res.setting = SHT_START;
            end
          end
          PH_FBL: begin
            res.mode = MODE_FBL;
            if (cls == CLS_GOOD || cls == CLS_BOTH) begin
              phase_nxt   = PH_IDLE;
              res.setting = SET_W'(sv_r);
              res.fin     = 1'b1;
              res.status  = (cls == CLS_BOTH) ? ST_CONTRAST : ST_OK;
            end else if (fbl_out) begin
              phase_nxt   = PH_IDLE;
              sv_nxt      = adj;
              res.setting = (adj > SV_W'(FBL_MAX)) ? FBL_MAX : SET_ONE;
              res.fin     = 1'b1;
              res.status  = ST_RANGE;
            end else begin
              sv_nxt      = adj;
              step_nxt    = (step_r + CNT_W'(1)) >> 1;
              res.setting = SET_W'(adj);
            end
          end
          PH_SHT: begin
            res.mode = MODE_SHT;
            if (cls == CLS_GOOD || cls == CLS_BOTH) begin
              phase_nxt   = PH_IDLE;
              res.setting = SET_W'(rnd);
              res.fin     = 1'b1;
              res.status  = (cls == CLS_BOTH) ? ST_CONTRAST : ST_OK;
            end else if (sht_out) begin
              phase_nxt   = PH_IDLE;
              sv_nxt      = adj;
              res.setting = sht_high ? SHT_MAX : SET_ONE;
              res.fin     = 1'b1;
              res.status  = ST_RANGE;
            end else begin
              sv_nxt      = adj;
              step_nxt    = step_r >> 1;
              res.setting = SET_W'(rnd);
            end
          end
          PH_IDLE: begin
            has_res = 1'b0;
          end
          default: begin
            has_res = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      dark_cnt_r <= '0;
      sat_cnt_r  <= '0;
      sv_r       <= '0;
      step_r     <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      dark_cnt_r <= dark_cnt_nxt;
      sat_cnt_r  <= sat_cnt_nxt;
      sv_r       <= sv_nxt;
      step_r     <= step_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/auto_exposure_search_core.sv
// Top level of the auto exposure search core: stream ports, configuration
// registers, input and result registers. Depends on aes_pkg and the aes_ modules.
//
//  channel | direction | handshake           | contents
//  --------+-----------+---------------------+-------------------------------------
//  in_     | slave     | in_tvalid/in_tready | pixel, opcode, last pixel
//  out_    | master    | out_tvalid/out_tready| setting, status, class, mode, final
//  cfg_    | slave     | cfg_valid/cfg_ready | register index and write data
//
// One item per clock unless a held result stalls. An item enters the input register
// on its transfer and its result, if any, the result register when the stage fires.
// A stalled result register still lets items in while the input register moves.
// Reset: synchronous, active low; the channels go ready in the cycle after release.
// Percent/frame_pixels writes reach the frame-end compare via their register and two
// registered multiplies; fixed_time_us writes reach the conversion via one of each.
`default_nettype none

module auto_exposure_search_core
  import aes_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [11:0] pixel
  input  wire logic                  in_tuser,   // [0] opcode
  input  wire logic                  in_tlast,   // last pixel of the frame
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [15:0]           out_tdata,  // [10:0] setting, [12:11] status,
                                                 // [14:13] frame_class
  output logic                       out_tuser,  // [0] exposure_mode
  output logic                       out_tlast,  // final_res
  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic              run_r;
  logic              fixed_mode_r;
  logic [TIME_W-1:0] fixed_time_r;
  logic [DARK_W-1:0] dark_level_r;
  logic [PCT_W-1:0]  percent_r;
  logic [FPIX_W-1:0] frame_pixels_r;

  item_t item_r;
  logic  in_v_r;
  res_t  res_r;
  logic  out_v_r;

  logic             fire;
  logic             has_res;
  res_t             res;
  logic [LIM_W-1:0] limit;
  fixed_t           fixed_res;

  // Ready after reset release
  always_ff @(posedge clk) begin
    if (!rst_n) run_r <= 1'b0;
    else        run_r <= 1'b1;
  end

  assign cfg_ready = run_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_mode_r   <= 1'b0;
      fixed_time_r   <= '0;
      dark_level_r   <= DARK_W'(64);
      percent_r      <= PCT_W'(5);
      frame_pixels_r <= FPIX_W'(1376256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIXED_MODE:   fixed_mode_r   <= cfg_data[0];
        CFG_FIXED_TIME:   fixed_time_r   <= cfg_data[TIME_W-1:0];
        CFG_DARK_LEVEL:   dark_level_r   <= cfg_data[DARK_W-1:0];
        CFG_PERCENT:      percent_r      <= cfg_data[PCT_W-1:0];
        CFG_FRAME_PIXELS: frame_pixels_r <= cfg_data[FPIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage fires on a valid item unless it has a result and the result register is held
  assign fire      = in_v_r && (!has_res || !out_v_r || out_tready);
  assign in_tready = run_r && (!in_v_r || fire);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{op: in_tuser, pixel: in_tdata[PIX_W-1:0], last: in_tlast};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && has_res) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) res_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, res_r.cls, res_r.status, res_r.setting};
  assign out_tuser  = res_r.mode;
  assign out_tlast  = res_r.fin;

  aes_limit_calc u_limit (
    .clk          (clk),
    .frame_pixels (frame_pixels_r),
    .percent      (percent_r),
    .limit        (limit)
  );

  aes_fixed_conv u_fixed (
    .clk       (clk),
    .time_us   (fixed_time_r),
    .fixed_res (fixed_res)
  );

  aes_search_fsm u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item_r),
    .fixed_mode (fixed_mode_r),
    .dark_level (dark_level_r),
    .limit      (limit),
    .fixed_res  (fixed_res),
    .has_res    (has_res),
    .res        (res)
  );

endmodule

`default_nettype wire

>>> design/aes_checker.sv
// Port-level checks of the auto exposure search core, bound to the top level.
// Depends on aes_pkg.
`default_nettype none

module aes_checker
  import aes_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [15:0]           in_tdata,
  input wire logic                  in_tuser,
  input wire logic                  in_tlast,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [15:0]           out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Reset quiets every channel in the next cycle
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready && !cfg_ready)
    else $error("channel active right after reset");

  // A held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Blanking counts stay within 1..12
  a_fbl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == MODE_FBL |->
    out_tdata[SET_W-1:0] >= SET_ONE && out_tdata[SET_W-1:0] <= FBL_MAX)
    else $error("blanking count out of range");

  // High contrast ends the search and comes only from a frame with both conditions
  a_contrast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12:11] == ST_CONTRAST |->
    out_tlast && out_tdata[14:13] == CLS_BOTH)
    else $error("contrast status without both conditions or not final");

  // Any non-ok status is a final result
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12:11] != ST_OK |-> out_tlast)
    else $error("error status on a non-final result");

endmodule

bind auto_exposure_search_core aes_checker u_aes_checker (.*);

`default_nettype wire
